// ----- hdl/wpsd_pkg.sv -----
package wpsd_pkg;

	localparam int PH_W    = 16;
	localparam int D_W     = 17;
	localparam int SQ_W    = 32;
	localparam int GRP_W   = 34;
	localparam int SUM_W   = 36;
	localparam int Q_W     = 18;
	localparam int REM_W   = 20;
	localparam int NPAIR   = 13;
	localparam int NAXIS   = 3;
	localparam int NST     = 24;
	localparam int RT_FIRST = 7;
	localparam int RT_N    = Q_W;

	localparam logic [1:0] REG_DIM_X = 2'd0;
	localparam logic [1:0] REG_DIM_Y = 2'd1;
	localparam logic [1:0] REG_DIM_Z = 2'd2;
	localparam logic [1:0] REG_MODE  = 2'd3;

	localparam logic [8:0]  DIM_XY_MIN = 9'd3;
	localparam logic [8:0]  DIM_XY_MAX = 9'd256;
	localparam logic [10:0] DIM_Z_MIN  = 11'd3;
	localparam logic [10:0] DIM_Z_MAX  = 11'd1024;
	localparam logic [17:0] QUALITY_MAX = 18'd236294;

	// neighbour offsets (x, y, z) of one side of each opposing pair, axis pairs first
	localparam int PAIR_OFF [NPAIR][3] = '{
		'{-1, 0, 0}, '{0, -1, 0}, '{0, 0, -1}, '{-1, -1, 0}, '{1, -1, 0},
		'{-1, -1, -1}, '{0, -1, -1}, '{1, -1, -1}, '{-1, 0, -1}, '{1, 0, -1},
		'{-1, 1, -1}, '{0, 1, -1}, '{1, 1, -1}
	};

	typedef logic signed [PH_W-1:0] phase_t;
	typedef logic signed [D_W-1:0]  sdiff_t;

	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
		logic [9:0] z;
		logic       last;
	} meta_t;

endpackage

// ----- hdl/wrapped_phase_second_difference_3d_core.sv -----
// Streams wrapped phase voxels (x fastest, then y, then z) and returns, for every interior
// voxel, the floor square root of the summed squared wrapped second differences with its
// coordinates; border voxels give no word. One voxel is taken every cycle unless a result
// word that is not taken holds the pipeline. The diagonal pairs count only while the mode
// bit is set. A voxel passes through the history read, the window, the differences, squares
// and adder tree, the final sum and then the 18-step square root, one result bit per step.
// History sits in a 64K x 32 frame store (previous two slices) and a 256 x 96 row store, each
// read and written once per voxel. A configuration write restarts the volume at the origin.
module wrapped_phase_second_difference_3d_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               phase_valid,
	output logic               phase_stall,
	input  logic signed [15:0] phase,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [17:0]        quality,
	output logic [7:0]         pos_x,
	output logic [7:0]         pos_y,
	output logic [9:0]         pos_z,
	output logic               last,
	input  logic               write_en,
	input  logic [1:0]         write_index,
	input  logic [10:0]        write_data
);

	logic [8:0]  dim_x_q, dim_y_q;
	logic [10:0] dim_z_q;
	logic        mode_q;
	logic [7:0]  col_q, row_q;
	logic [9:0]  slice_q;

	logic [8:0]  dx, dy;
	logic [10:0] dz;
	logic        col_end, row_end, slc_end;
	logic        en, acc;

	logic [wpsd_pkg::NST:1] vld;

	logic [31:0] frame_mem [65536];
	logic [95:0] row_mem [256];

	// stage 1
	wpsd_pkg::phase_t phase_s1;
	logic [15:0]      addr_s1;
	logic [31:0]      fr_rd_s1;
	logic [95:0]      row_rd_s1;
	logic             prod_s1;
	wpsd_pkg::meta_t  meta_s1;
	wpsd_pkg::phase_t col [3][3];

	// stage 2
	wpsd_pkg::phase_t win_s2 [3][3][3];
	logic             prod_s2;
	wpsd_pkg::meta_t  meta_s2;

	// stages 3 to 6
	wpsd_pkg::sdiff_t              d_nxt [wpsd_pkg::NPAIR];
	wpsd_pkg::sdiff_t              d_s3 [wpsd_pkg::NPAIR];
	logic [wpsd_pkg::SQ_W-1:0]     sq_s4 [wpsd_pkg::NPAIR];
	logic [wpsd_pkg::GRP_W-1:0]    grp_s5 [4];
	logic [wpsd_pkg::SUM_W-1:0]    sum_s6;
	wpsd_pkg::meta_t               meta_s3, meta_s4, meta_s5, meta_s6;

	// square root stages, index k is stage 7 + k
	logic [wpsd_pkg::REM_W-1:0] rt_rem_s7 [wpsd_pkg::RT_N];
	logic [wpsd_pkg::Q_W-1:0]   rt_root_s7 [wpsd_pkg::RT_N];
	logic [wpsd_pkg::SUM_W-1:0] rt_rad_s7 [wpsd_pkg::RT_N];
	wpsd_pkg::meta_t            rt_meta_s7 [wpsd_pkg::RT_N];
	logic [wpsd_pkg::REM_W-1:0] rem_nxt [wpsd_pkg::RT_N];
	logic [wpsd_pkg::Q_W-1:0]   root_nxt [wpsd_pkg::RT_N];
	logic [wpsd_pkg::SUM_W-1:0] rad_nxt [wpsd_pkg::RT_N];

	assign dx = (dim_x_q < wpsd_pkg::DIM_XY_MIN) ? wpsd_pkg::DIM_XY_MIN :
		(dim_x_q > wpsd_pkg::DIM_XY_MAX) ? wpsd_pkg::DIM_XY_MAX : dim_x_q;
	assign dy = (dim_y_q < wpsd_pkg::DIM_XY_MIN) ? wpsd_pkg::DIM_XY_MIN :
		(dim_y_q > wpsd_pkg::DIM_XY_MAX) ? wpsd_pkg::DIM_XY_MAX : dim_y_q;
	assign dz = (dim_z_q < wpsd_pkg::DIM_Z_MIN) ? wpsd_pkg::DIM_Z_MIN :
		(dim_z_q > wpsd_pkg::DIM_Z_MAX) ? wpsd_pkg::DIM_Z_MAX : dim_z_q;

	assign col_end = ({1'b0, col_q} == dx - 9'd1);
	assign row_end = ({1'b0, row_q} == dy - 9'd1);
	assign slc_end = ({1'b0, slice_q} == dz - 11'd1);

	// whole pipeline moves together, held only by a result word that is not taken
	assign en          = !(vld[wpsd_pkg::NST] && result_stall);
	assign acc         = phase_valid && en;
	assign phase_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_x_q <= 9'd64;
			dim_y_q <= 9'd64;
			dim_z_q <= 11'd64;
			mode_q  <= 1'b1;
		end else if (write_en) begin
			case (write_index)
				wpsd_pkg::REG_DIM_X: dim_x_q <= write_data[8:0];
				wpsd_pkg::REG_DIM_Y: dim_y_q <= write_data[8:0];
				wpsd_pkg::REG_DIM_Z: dim_z_q <= write_data;
				wpsd_pkg::REG_MODE:  mode_q  <= write_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			slice_q <= '0;
		end else if (write_en) begin
			col_q   <= '0;
			row_q   <= '0;
			slice_q <= '0;
		end else if (acc) begin
			if (col_end) begin
				col_q <= '0;
				if (row_end) begin
					row_q <= '0;
					slice_q <= slc_end ? 10'd0 : slice_q + 10'd1;
				end else begin
					row_q <= row_q + 8'd1;
				end
			end else begin
				col_q <= col_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (en) begin
			vld[1] <= phase_valid;
			vld[2] <= vld[1];
			vld[3] <= vld[2] && prod_s2;
			for (int k = 4; k <= wpsd_pkg::NST; k++) begin
				vld[k] <= vld[k-1];
			end
		end
	end

	// history stores: read as a voxel enters, written back as it moves on
	always_ff @(posedge clk) begin
		if (en) begin
			fr_rd_s1  <= frame_mem[{row_q, col_q}];
			row_rd_s1 <= row_mem[col_q];
		end
		if (en && vld[1]) begin
			frame_mem[addr_s1] <= {fr_rd_s1[15:0], phase_s1};
			row_mem[addr_s1[7:0]] <= {col[1][2], col[0][2], col[1][1], col[0][1],
				col[1][0], col[0][0]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phase_s1  <= phase;
			addr_s1   <= {row_q, col_q};
			prod_s1   <= (col_q >= 8'd2) && (row_q >= 8'd2) && (slice_q >= 10'd2);
			meta_s1.x <= col_q - 8'd1;
			meta_s1.y <= row_q - 8'd1;
			meta_s1.z <= slice_q - 10'd1;
			meta_s1.last <= col_end && row_end && slc_end;
		end
	end

	// column of nine samples at the current x: [y back][z back]
	always_comb begin
		col[0][0] = phase_s1;
		col[0][1] = fr_rd_s1[15:0];
		col[0][2] = fr_rd_s1[31:16];
		for (int z = 0; z < 3; z++) begin
			col[1][z] = row_rd_s1[z*32 +: 16];
			col[2][z] = row_rd_s1[z*32 + 16 +: 16];
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld[1]) begin
			for (int y = 0; y < 3; y++) begin
				for (int z = 0; z < 3; z++) begin
					win_s2[2][y][z] <= win_s2[1][y][z];
					win_s2[1][y][z] <= win_s2[0][y][z];
					win_s2[0][y][z] <= col[y][z];
				end
			end
			prod_s2 <= prod_s1;
			meta_s2 <= meta_s1;
		end
	end

	// wrapped second differences; 16-bit truncation is the modular wrap
	always_comb begin
		logic [15:0] m, a, b, da, db;
		m = win_s2[1][1][1];
		for (int p = 0; p < wpsd_pkg::NPAIR; p++) begin
			a = win_s2[2'(1 - wpsd_pkg::PAIR_OFF[p][0])][2'(1 - wpsd_pkg::PAIR_OFF[p][1])]
				[2'(1 - wpsd_pkg::PAIR_OFF[p][2])];
			b = win_s2[2'(1 + wpsd_pkg::PAIR_OFF[p][0])][2'(1 + wpsd_pkg::PAIR_OFF[p][1])]
				[2'(1 + wpsd_pkg::PAIR_OFF[p][2])];
			da = a - m;
			db = m - b;
			d_nxt[p] = $signed({da[15], da}) - $signed({db[15], db});
			if (!mode_q && p >= wpsd_pkg::NAXIS) begin
				d_nxt[p] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			logic signed [2*wpsd_pkg::D_W-1:0] pr;
			for (int p = 0; p < wpsd_pkg::NPAIR; p++) begin
				d_s3[p] <= d_nxt[p];
				pr = d_s3[p] * d_s3[p];
				sq_s4[p] <= pr[wpsd_pkg::SQ_W-1:0];
			end
			for (int g = 0; g < 3; g++) begin
				grp_s5[g] <= 34'(sq_s4[4*g]) + 34'(sq_s4[4*g+1]) + 34'(sq_s4[4*g+2])
					+ 34'(sq_s4[4*g+3]);
			end
			grp_s5[3] <= 34'(sq_s4[12]);
			sum_s6 <= 36'(grp_s5[0]) + 36'(grp_s5[1]) + 36'(grp_s5[2]) + 36'(grp_s5[3]);
			meta_s3 <= meta_s2;
			meta_s4 <= meta_s3;
			meta_s5 <= meta_s4;
			meta_s6 <= meta_s5;
		end
	end

	// one result bit per stage: bring down two radicand bits, try root*4+1
	always_comb begin
		logic [wpsd_pkg::REM_W-1:0] prem;
		logic [wpsd_pkg::Q_W-1:0]   proot;
		logic [wpsd_pkg::SUM_W-1:0] prad;
		logic [wpsd_pkg::REM_W+1:0] r, t;
		for (int k = 0; k < wpsd_pkg::RT_N; k++) begin
			if (k == 0) begin
				prem  = '0;
				proot = '0;
				prad  = sum_s6;
			end else begin
				prem  = rt_rem_s7[k-1];
				proot = rt_root_s7[k-1];
				prad  = rt_rad_s7[k-1];
			end
			r = {prem, prad[wpsd_pkg::SUM_W-1 -: 2]};
			t = {2'b00, proot, 2'b01};
			if (r >= t) begin
				rem_nxt[k]  = wpsd_pkg::REM_W'(r - t);
				root_nxt[k] = {proot[wpsd_pkg::Q_W-2:0], 1'b1};
			end else begin
				rem_nxt[k]  = wpsd_pkg::REM_W'(r);
				root_nxt[k] = {proot[wpsd_pkg::Q_W-2:0], 1'b0};
			end
			rad_nxt[k] = {prad[wpsd_pkg::SUM_W-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_meta_s7[0] <= meta_s6;
			for (int k = 0; k < wpsd_pkg::RT_N; k++) begin
				rt_rem_s7[k]  <= rem_nxt[k];
				rt_root_s7[k] <= root_nxt[k];
				rt_rad_s7[k]  <= rad_nxt[k];
			end
			for (int k = 1; k < wpsd_pkg::RT_N; k++) begin
				rt_meta_s7[k] <= rt_meta_s7[k-1];
			end
		end
	end

	assign result_valid = vld[wpsd_pkg::NST];
	assign quality      = rt_root_s7[wpsd_pkg::RT_N-1];
	assign pos_x        = rt_meta_s7[wpsd_pkg::RT_N-1].x;
	assign pos_y        = rt_meta_s7[wpsd_pkg::RT_N-1].y;
	assign pos_z        = rt_meta_s7[wpsd_pkg::RT_N-1].z;
	assign last         = rt_meta_s7[wpsd_pkg::RT_N-1].last;

endmodule

// ----- hdl/wpsd_checker.sv -----
module wpsd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               phase_valid,
	input logic               phase_stall,
	input logic signed [15:0] phase,
	input logic               result_valid,
	input logic               result_stall,
	input logic [17:0]        quality,
	input logic [7:0]         pos_x,
	input logic [7:0]         pos_y,
	input logic [9:0]         pos_z,
	input logic               last
);

	// a held result word keeps its contents
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(quality) && $stable(pos_x)
			&& $stable(pos_y) && $stable(pos_z) && $stable(last))
		else $error("result word changed while stalled");

	// a stalled input word stays in place
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		phase_valid && phase_stall |=> phase_valid && $stable(phase))
		else $error("input word changed while stalled");

	// square root of at most thirteen 17-bit squares
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> quality <= wpsd_pkg::QUALITY_MAX)
		else $error("quality beyond largest possible root");

	// centres on the low border (coordinate zero) never produce a word
	a_border: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pos_x != 8'd0 && pos_y != 8'd0 && pos_z != 10'd0)
		else $error("result on a border voxel");

endmodule

bind wrapped_phase_second_difference_3d_core wpsd_checker u_wpsd_checker (.*);
